// ===== rtl/image_crc32_trailer_appender_top_macros.svh =====
// ----------------------------------------------------------------------------
// image crc32 trailer appender assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef IMAGE_CRC32_TRAILER_APPENDER_TOP_MACROS_SVH
`define IMAGE_CRC32_TRAILER_APPENDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ICTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICTA_ASSERT(lbl, clk, rst_n, prop, msg)
`define ICTA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/icta_pkg.sv =====
// ----------------------------------------------------------------------------
// icta_pkg
// types, constants and the crc byte step of the image crc32 trailer appender
// ----------------------------------------------------------------------------
package icta_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;
  localparam logic [31:0] OuterReset = 32'h5A5A5A5A;
  localparam logic [31:0] InnerReset = 32'h51709394;

  localparam int unsigned TrailerBytes = 24;
  localparam int unsigned TrlIdxW      = $clog2(TrailerBytes);
  localparam logic [TrlIdxW-1:0] TrlIdxLast = TrlIdxW'(TrailerBytes - 1);

  // trailer word positions
  localparam logic [2:0] WordOuterHead = 3'd0;
  localparam logic [2:0] WordInnerHead = 3'd1;
  localparam logic [2:0] WordLength    = 3'd2;
  localparam logic [2:0] WordCrc       = 3'd3;
  localparam logic [2:0] WordInnerTail = 3'd4;
  localparam logic [2:0] WordOuterTail = 3'd5;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgOuterMarker = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInnerMarker = 2'd1;

  // request actions
  localparam logic ActData   = 1'b0;
  localparam logic ActFinish = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } icta_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_trailer;
    logic       last;
  } icta_rsp_t;

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc,
                                                input logic [7:0]  b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/image_crc32_trailer_appender_top.sv =====
// output: a data request shows on the output in the cycle after it is taken
// throughput: one data byte per cycle while the output is not stalled; a finish request
//   emits 24 trailer bytes, counted by the trailer byte counter, and blocks input meanwhile
// reset: rst_ni clears crc to all ones, count to zero, markers to defaults,
//   and empties the output register
// ----------------------------------------------------------------------------
// image_crc32_trailer_appender_top
// passes image bytes through, folds them into a crc-32, appends a trailer
// ----------------------------------------------------------------------------
`include "image_crc32_trailer_appender_top_macros.svh"

module image_crc32_trailer_appender_top
  import icta_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  icta_req_t          in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icta_rsp_t          out_rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  logic [31:0]        outer_q, inner_q;
  logic [31:0]        crc_q, crc_d;
  logic [31:0]        count_q, count_d;
  logic [31:0]        len_q, len_d;
  logic [31:0]        fcrc_q, fcrc_d;
  logic               trl_active_q, trl_active_d;
  logic [TrlIdxW-1:0] trl_idx_q, trl_idx_d;
  logic               out_valid_q, out_valid_d;
  icta_rsp_t          out_rsp_q, out_rsp_d;

  logic               out_free;
  logic               in_fire;
  logic [31:0]        word_sel;
  logic [7:0]         trl_byte;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !trl_active_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= OuterReset;
      inner_q <= InnerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOuterMarker: outer_q <= cfg_wdata_i;
        CfgInnerMarker: inner_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // trailer byte select, live index or index zero at finish
  logic [TrlIdxW-1:0] sel_idx;
  assign sel_idx = trl_active_q ? trl_idx_q : '0;

  always_comb begin
    unique case (sel_idx[TrlIdxW-1:2]) inside
      WordOuterHead, WordOuterTail: word_sel = outer_q;
      WordInnerHead, WordInnerTail: word_sel = inner_q;
      WordLength:                   word_sel = len_q;
      WordCrc:                      word_sel = fcrc_q;
      default:                      word_sel = outer_q;
    endcase
  end

  assign trl_byte = 8'(word_sel >> {sel_idx[1:0], 3'b000});

  always_comb begin
    crc_d        = crc_q;
    count_d      = count_q;
    len_d        = len_q;
    fcrc_d       = fcrc_q;
    trl_active_d = trl_active_q;
    trl_idx_d    = trl_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_rsp_d    = out_rsp_q;

    if (in_fire) begin
      out_valid_d = 1'b1;
      if (in_req_i.action == ActData) begin
        crc_d     = crc_fold_byte(crc_q, in_req_i.data_byte);
        count_d   = count_q + 32'd1;
        out_rsp_d = '{out_byte: in_req_i.data_byte, is_trailer: 1'b0, last: 1'b0};
      end else begin
        len_d        = count_q;
        fcrc_d       = ~crc_q;
        crc_d        = CrcInit;
        count_d      = '0;
        trl_active_d = 1'b1;
        trl_idx_d    = TrlIdxW'(1);
        out_rsp_d    = '{out_byte: outer_q[7:0], is_trailer: 1'b1, last: 1'b0};
      end
    end else if (trl_active_q && out_free) begin
      out_valid_d = 1'b1;
      out_rsp_d   = '{out_byte: trl_byte, is_trailer: 1'b1,
                      last: (trl_idx_q == TrlIdxLast)};
      if (trl_idx_q == TrlIdxLast) begin
        trl_active_d = 1'b0;
        trl_idx_d    = '0;
      end else begin
        trl_idx_d    = trl_idx_q + TrlIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= CrcInit;
      count_q      <= '0;
      trl_active_q <= 1'b0;
      trl_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      crc_q        <= crc_d;
      count_q      <= count_d;
      trl_active_q <= trl_active_d;
      trl_idx_q    <= trl_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    fcrc_q    <= fcrc_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `ICTA_ASSERT(a_no_input_in_trailer, clk_i, rst_ni, trl_active_q |-> !in_ready_o, "input taken during trailer")
  `ICTA_ASSERT_ALWAYS(a_last_is_trailer, clk_i, (out_valid_o && out_rsp_o.last) |-> out_rsp_o.is_trailer, "last outside trailer")
  `ICTA_ASSERT(a_finish_restarts, clk_i, rst_ni, (in_fire && in_req_i.action == ActFinish) |=> (trl_active_q && crc_q == CrcInit && count_q == 32'd0), "finish did not restart crc")
  `ICTA_ASSERT(a_last_ends_trailer, clk_i, rst_ni, (out_valid_o && out_rsp_o.last) |-> !trl_active_q, "trailer still active at last byte")

endmodule
